FILE: sv/ple_pkg.sv
// Shared constants, codes and control structs for the positional list engine.
package ple_pkg;

  // List capacity and derived widths
  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Fixed field widths
  localparam int FUNC_W = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  // Common width for comparing a position against the count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS  = FUNC_W + VAL_W + POS_W;
  localparam int OUT_BITS = STAT_W + LEN_W + VAL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_INS_POS  = 3'd2,
    FN_DEL_POS  = 3'd3,
    FN_LIST     = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;        // run a single-result operation and load its result
    logic list_start;  // begin walking the list from the head
    logic emit;        // load the current element into the output register
  } ple_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero;  // list holds no element
    logic emit_last;   // current walk index is the tail
    logic out_free;    // output register can take an item this cycle
  } ple_stat_t;

  // Length field: low bits of the count
  function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(c);
    return ext[LEN_W-1:0];
  endfunction

endpackage

FILE: sv/ple_ctrl.sv
// Controller state machine: input acceptance and list walk sequencing.
module ple_ctrl import ple_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] func_i,
  input  ple_stat_t         st_i,
  output logic              in_ready_o,
  output ple_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   is_walk;

  // Take an item only when idle and the output register has room
  assign in_ready_o = (state_q == S_IDLE) && st_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_walk    = (func_i == FN_LIST) && !st_i.count_zero;

  // Issue commands
  always_comb begin
    cmd_o.exec       = accept && !is_walk;
    cmd_o.list_start = accept && is_walk;
    cmd_o.emit       = (state_q == S_LIST) && st_i.out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.list_start) state_d = S_LIST;
      end
      S_LIST: begin
        if (cmd_o.emit && st_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_no_accept_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> !in_ready_o)
    else $error("item accepted during list walk");

  a_start_enters_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.list_start |=> (state_q == S_LIST))
    else $error("list start did not enter walk");

  a_walk_ends_on_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && $past(state_q == S_LIST)) |->
      $past(cmd_o.emit && st_i.emit_last))
    else $error("walk left before tail element");
`endif

endmodule

FILE: sv/ple_dp.sv
// Datapath: shift-array list cells, count, walk index and output register.
module ple_dp import ple_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ple_cmd_t          cmd_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic              out_ready_i,
  output ple_stat_t         st_o,
  output logic              out_valid_o,
  output logic [STAT_W-1:0] out_status_o,
  output logic [LEN_W-1:0]  out_length_o,
  output logic [VAL_W-1:0]  out_element_o,
  output logic              out_last_o
);

  logic [VAL_W-1:0]  entries_q [LIST_DEPTH];
  logic [VAL_W-1:0]  entries_d [LIST_DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic              ovalid_q, ovalid_d;
  logic [STAT_W-1:0] ostatus_q, ostatus_d;
  logic [LEN_W-1:0]  olength_q, olength_d;
  logic [VAL_W-1:0]  oelement_q, oelement_d;
  logic              olast_q, olast_d;

  logic              full, empty, out_free, emit_last;
  logic [CMP_W-1:0]  pos_ext, cnt_ext, ins_pos, ins_sel, del_p, del_idx;
  logic              do_ins, do_del;
  status_e           res_status;

  assign full      = (count_q == CNT_W'(LIST_DEPTH));
  assign empty     = (count_q == '0);
  assign out_free  = !ovalid_q || out_ready_i;
  assign emit_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  always_comb begin
    st_o.count_zero = empty;
    st_o.emit_last  = emit_last;
    st_o.out_free   = out_free;
  end

  // Clamp insert and delete positions to the current length
  always_comb begin
    pos_ext = CMP_W'(pos_i);
    cnt_ext = CMP_W'(count_q);
    ins_pos = (pos_ext >= cnt_ext) ? cnt_ext : pos_ext;
    del_p   = (pos_ext == '0) ? CMP_W'(1) : pos_ext;
    if (del_p > cnt_ext) del_p = cnt_ext;
    del_idx = del_p - CMP_W'(1);
  end

  // Decode the operation
  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    res_status = ST_OK;
    ins_sel    = ins_pos;
    unique case (func_i)
      FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
        if (full) res_status = ST_FULL;
        else      do_ins     = 1'b1;
        if (func_i == FN_INS_HEAD)      ins_sel = '0;
        else if (func_i == FN_INS_TAIL) ins_sel = cnt_ext;
      end
      FN_DEL_POS: begin
        if (empty) res_status = ST_EMPTY;
        else       do_del     = 1'b1;
      end
      FN_LIST: begin
        // reached only for an empty list
        res_status = ST_EMPTY;
      end
      default: res_status = ST_OK;
    endcase
  end

  // Shift the cells for an insert or a delete
  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    if (cmd_i.exec && do_ins) begin
      for (int i = 1; i < LIST_DEPTH; i++) begin
        if (CMP_W'(i) > ins_sel) entries_d[i] = entries_q[i-1];
      end
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (CMP_W'(i) == ins_sel) entries_d[i] = value_i;
      end
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.exec && do_del) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        if (CMP_W'(i) >= del_idx) entries_d[i] = entries_q[i+1];
      end
      count_d = count_q - CNT_W'(1);
    end
  end

  // Advance the walk index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.list_start)  idx_d = '0;
    else if (cmd_i.emit)   idx_d = idx_q + IDX_W'(1);
  end

  // Load the output register
  always_comb begin
    ovalid_d   = ovalid_q;
    ostatus_d  = ostatus_q;
    olength_d  = olength_q;
    oelement_d = oelement_q;
    olast_d    = olast_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (cmd_i.exec) begin
      ovalid_d   = 1'b1;
      ostatus_d  = res_status;
      olength_d  = to_len(count_d);
      oelement_d = '0;
      olast_d    = 1'b1;
    end else if (cmd_i.emit) begin
      ovalid_d   = 1'b1;
      ostatus_d  = ST_OK;
      olength_d  = to_len(count_q);
      oelement_d = entries_q[idx_q];
      olast_d    = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    entries_q  <= entries_d;
    ostatus_q  <= ostatus_d;
    olength_q  <= olength_d;
    oelement_q <= oelement_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign out_status_o  = ostatus_q;
  assign out_length_o  = olength_q;
  assign out_element_o = oelement_q;
  assign out_last_o    = olast_q;

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("count beyond list depth");

  a_full_insert_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (res_status == ST_FULL)) |=> (count_q == $past(count_q)))
    else $error("rejected insert changed count");

  a_walk_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (CNT_W'(idx_q) < count_q))
    else $error("walk index past tail");
`endif

endmodule

FILE: sv/positional_list_engine_core.sv
// Top level of the positional list engine: stream ports, controller and datapath.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: func[2:0] value[34:3] pos[39:35]
//  m_axis   | out | m_axis_tvalid/tready   | tdata: status length element; tlast
//
//  Insert, delete and other single-result items each give one result; a new
//  item is taken every cycle while the output register drains.
//  A list item on a non-empty list first starts the walk, then emits one result
//  per element, one a cycle while the single output register drains; no item is
//  taken during that walk, so the input stays closed until the tail is emitted.
//  A stalled output holds its item and blocks new input until taken.
//  Reset empties the list; cell contents are not cleared.
module positional_list_engine_core import ple_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // func, value, position (low bit up)
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // status, length, element, zero pad
  output logic             m_axis_tlast    // last result of the item
);

  ple_cmd_t          cmd;
  ple_stat_t         st;
  logic [FUNC_W-1:0] func;
  logic [VAL_W-1:0]  value;
  logic [POS_W-1:0]  pos;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  length;
  logic [VAL_W-1:0]  element;

  // Unpack input fields
  assign func  = s_axis_tdata[FUNC_W-1:0];
  assign value = s_axis_tdata[FUNC_W+VAL_W-1:FUNC_W];
  assign pos   = s_axis_tdata[IN_BITS-1:FUNC_W+VAL_W];

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .func_i     (func),
    .st_i       (st),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  ple_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func),
    .value_i       (value),
    .pos_i         (pos),
    .out_ready_i   (m_axis_tready),
    .st_o          (st),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (status),
    .out_length_o  (length),
    .out_element_o (element),
    .out_last_o    (m_axis_tlast)
  );

  // Pack output fields
  assign m_axis_tdata = {{(OUT_W - OUT_BITS){1'b0}}, element, length, status};

endmodule
